// ===== rtl/core/vaos_pkg.sv =====
// ----------------------------------------------------------------------------
// vaos_pkg
// Shared types and codes for the polyphonic voice allocator with
// oldest-note stealing.
// ----------------------------------------------------------------------------
`default_nettype none

package vaos_pkg;

  // default sizing, handed to the top level parameters
  localparam int unsigned VOICE_COUNT_DEF = 8;
  localparam int unsigned AGE_BITS_DEF    = 32;

  // fixed field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned NOTE_W   = 7;
  localparam int unsigned VEL_W    = 7;
  localparam int unsigned FIN_W    = 3;
  localparam int unsigned CHOSEN_W = 3;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned MASK_W   = 8;

  // request operations
  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON    = 3'd0,
    OP_NOTE_OFF   = 3'd1,
    OP_ALL_OFF    = 3'd2,
    OP_VOICE_DONE = 3'd3,
    OP_KILL_ALL   = 3'd4
  } op_e;

  // how the chosen voice was obtained
  typedef enum logic [KIND_W-1:0] {
    KIND_FREE     = 2'd0,
    KIND_RELEASED = 2'd1,
    KIND_STOLEN   = 2'd2
  } kind_e;

  // request payload
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [NOTE_W-1:0] note_number;
    logic [VEL_W-1:0]  note_velocity;
    logic [FIN_W-1:0]  finished_voice;
  } req_t;

  // result payload
  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen_voice;
    logic [KIND_W-1:0]   steal_kind;
    logic [NOTE_W-1:0]   start_note;
    logic [VEL_W-1:0]    start_velocity;
    logic [MASK_W-1:0]   released_mask;
    logic                started;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/vaos_oldest.sv =====
// ----------------------------------------------------------------------------
// vaos_oldest
// Combinational tournament tree that finds the smallest key; on equal keys
// the lower index wins.
// ----------------------------------------------------------------------------
`default_nettype none

module vaos_oldest #(
  parameter int unsigned N  = 8,
  parameter int unsigned KW = 33
) (
  input  wire logic [N-1:0][KW-1:0]                key_i,
  output      logic [((N > 1) ? $clog2(N) : 1)-1:0] idx_o,
  output      logic [KW-1:0]                       key_o
);

  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned LV = (N > 1) ? $clog2(N) : 0;
  localparam int unsigned P  = 1 << LV;
  localparam int unsigned NN = 2 * P - 1;

  logic [NN-1:0][KW-1:0] node_key;
  logic [NN-1:0][IW-1:0] node_idx;

  // leaves, padded with the largest key so real voices win ties
  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < N) begin : g_real
      assign node_key[P-1+j] = key_i[j];
    end else begin : g_pad
      assign node_key[P-1+j] = '1;
    end
    assign node_idx[P-1+j] = IW'(j);
  end

  // internal nodes: the right child wins only when strictly smaller
  for (genvar n = 0; n < P - 1; n++) begin : g_node
    logic right_win;
    assign right_win   = node_key[2*n+2] < node_key[2*n+1];
    assign node_key[n] = right_win ? node_key[2*n+2] : node_key[2*n+1];
    assign node_idx[n] = right_win ? node_idx[2*n+2] : node_idx[2*n+1];
  end

  assign idx_o = node_idx[0];
  assign key_o = node_key[0];

endmodule

`default_nettype wire

// ===== rtl/core/vaos_voice_bank.sv =====
// ----------------------------------------------------------------------------
// vaos_voice_bank
// Voice state (used, gate, note, age) and the age stamp counter; works out
// one registered request per cycle and updates the state at the same edge.
// ----------------------------------------------------------------------------
`default_nettype none

module vaos_voice_bank #(
  parameter int unsigned VOICE_COUNT = vaos_pkg::VOICE_COUNT_DEF,
  parameter int unsigned AGE_BITS    = vaos_pkg::AGE_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           vld_i,
  input  wire vaos_pkg::req_t req_i,
  output      vaos_pkg::rsp_t rsp_o
);

  import vaos_pkg::*;

  localparam int unsigned VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned KW = AGE_BITS + 1;

  logic [VOICE_COUNT-1:0] used_q, used_d;
  logic [VOICE_COUNT-1:0] gate_q, gate_d;
  logic [NOTE_W-1:0]      note_q [VOICE_COUNT];
  logic [NOTE_W-1:0]      note_d [VOICE_COUNT];
  logic [AGE_BITS-1:0]    age_q  [VOICE_COUNT];
  logic [AGE_BITS-1:0]    age_d  [VOICE_COUNT];
  logic [AGE_BITS-1:0]    stamp_q, stamp_d, stamp_inc;

  logic [VOICE_COUNT-1:0][KW-1:0] age_key;
  logic [VW-1:0]                  old_idx;
  logic [KW-1:0]                  old_key;
  logic [VW-1:0]                  free_idx;
  logic                           any_free;
  logic [VW-1:0]                  chosen;
  kind_e                          kind;
  logic [VOICE_COUNT-1:0]         released;
  op_e                            op;

  // lowest unused voice
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = VW'(i);
        any_free = 1'b1;
      end
    end
  end

  // released voices sort before gated ones, then by age
  always_comb begin
    for (int i = 0; i < VOICE_COUNT; i++) begin
      age_key[i] = {gate_q[i], age_q[i]};
    end
  end

  vaos_oldest #(
    .N  (VOICE_COUNT),
    .KW (KW)
  ) u_oldest (
    .key_i (age_key),
    .idx_o (old_idx),
    .key_o (old_key)
  );

  // voice choice and steal kind
  always_comb begin
    if (any_free) begin
      chosen = free_idx;
      kind   = KIND_FREE;
    end else begin
      chosen = old_idx;
      kind   = old_key[AGE_BITS] ? KIND_STOLEN : KIND_RELEASED;
    end
  end

  assign op        = op_e'(req_i.operation);
  assign stamp_inc = stamp_q + AGE_BITS'(1);

  // next state and result
  always_comb begin
    used_d   = used_q;
    gate_d   = gate_q;
    note_d   = note_q;
    age_d    = age_q;
    stamp_d  = stamp_q;
    released = '0;
    rsp_o    = '0;
    if (vld_i) begin
      unique case (op)
        OP_NOTE_ON: begin
          stamp_d              = stamp_inc;
          used_d[chosen]       = 1'b1;
          gate_d[chosen]       = 1'b1;
          note_d[chosen]       = req_i.note_number;
          age_d[chosen]        = stamp_inc;
          rsp_o.chosen_voice   = CHOSEN_W'(chosen);
          rsp_o.steal_kind     = kind;
          rsp_o.start_note     = req_i.note_number;
          rsp_o.start_velocity = req_i.note_velocity;
          rsp_o.started        = 1'b1;
        end
        OP_NOTE_OFF: begin
          for (int i = 0; i < VOICE_COUNT; i++) begin
            if (used_q[i] && gate_q[i] && (note_q[i] == req_i.note_number)) begin
              gate_d[i]   = 1'b0;
              released[i] = 1'b1;
            end
          end
        end
        OP_ALL_OFF, OP_KILL_ALL: begin
          released = gate_q;
          gate_d   = '0;
          if (op == OP_KILL_ALL) begin
            used_d = '0;
          end
        end
        OP_VOICE_DONE: begin
          for (int i = 0; i < VOICE_COUNT; i++) begin
            if (32'(req_i.finished_voice) == i) begin
              released[i] = gate_q[i];
              gate_d[i]   = 1'b0;
              used_d[i]   = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
      for (int b = 0; b < MASK_W; b++) begin
        if (b < VOICE_COUNT) begin
          rsp_o.released_mask[b] = released[b];
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      gate_q  <= '0;
      stamp_q <= '0;
    end else begin
      used_q  <= used_d;
      gate_q  <= gate_d;
      stamp_q <= stamp_d;
    end
  end

  // note and age per voice, only read once the voice was started
  always_ff @(posedge clk_i) begin
    note_q <= note_d;
    age_q  <= age_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/voice_allocator_oldest_steal_top.sv =====
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal_top
// Polyphonic voice allocator: note on, note off, all notes off, voice
// finished and kill all, with oldest-note stealing when all voices are used.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+------------------------
//   request   | start / busy              | req_i  (vaos_pkg::req_t)
//   result    | rsp_valid_o (one cycle)   | rsp_o  (vaos_pkg::rsp_t)
//
// One request is taken per cycle; busy stays low. A request taken at one edge
// is registered, worked out against the voice state in the next cycle, and
// its result strobes for one cycle after the following edge. The voice state
// updates at the same edge as the result register, so back-to-back requests
// see each other's effects. Reset clears all used and gate flags and the age
// counter; no clearing pass. Every request gives exactly one result; the
// receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_allocator_oldest_steal_top #(
  parameter int unsigned VOICE_COUNT = vaos_pkg::VOICE_COUNT_DEF,
  parameter int unsigned AGE_BITS    = vaos_pkg::AGE_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output      logic           busy,
  input  wire vaos_pkg::req_t req_i,
  output      logic           rsp_valid_o,
  output      vaos_pkg::rsp_t rsp_o
);

  import vaos_pkg::*;

  logic req_vld_q;
  req_t req_q;
  rsp_t rsp_d;
  rsp_t rsp_q;
  logic rsp_vld_q;

  // every cycle can take a request
  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  vaos_voice_bank #(
    .VOICE_COUNT (VOICE_COUNT),
    .AGE_BITS    (AGE_BITS)
  ) u_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (req_vld_q),
    .req_i  (req_q),
    .rsp_o  (rsp_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else begin
      rsp_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/core/vaos_checker.sv =====
// ----------------------------------------------------------------------------
// vaos_checker
// Port-level checks on the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vaos_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire vaos_pkg::req_t req_i,
  input wire logic           rsp_valid_o,
  input wire vaos_pkg::rsp_t rsp_o
);

  import vaos_pkg::*;

  // every accepted request gives a result
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 rsp_valid_o)
    else $error("request without result");

  // a result only follows an accepted request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(start && !busy, 2))
    else $error("result without request");

  // started exactly for note on requests
  a_started_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.started == ($past(req_i.operation, 2) == OP_NOTE_ON)))
    else $error("started flag does not match operation");

  // a started voice carries the request note and releases nothing
  a_start_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.started) |->
      ((rsp_o.start_note == $past(req_i.note_number, 2)) &&
       (rsp_o.start_velocity == $past(req_i.note_velocity, 2)) &&
       (rsp_o.released_mask == '0)))
    else $error("note on result mismatch");

  // no voice started means empty start fields
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.started) |->
      ((rsp_o.chosen_voice == '0) && (rsp_o.steal_kind == KIND_FREE) &&
       (rsp_o.start_note == '0) && (rsp_o.start_velocity == '0)))
    else $error("start fields set without a started voice");

endmodule

bind voice_allocator_oldest_steal_top vaos_checker u_vaos_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);

`default_nettype wire

// ===== bench/tb_voice_allocator_oldest_steal_top.sv =====
// ----------------------------------------------------------------------------
// tb_voice_allocator_oldest_steal_top
// Self-checking bench for the voice allocator. A scoreboard keeps its own copy
// of the voice table (used, gate, note, age stamp) and works out the response
// to every accepted request. Directed requests fill, steal, release and clear
// the voices. After them come random request streams that lean toward note on
// and note off on a narrow band of notes, so the allocator runs full most of
// the time. Request gaps are random, with one long stretch of back-to-back
// requests.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_voice_allocator_oldest_steal_top;
  import vaos_pkg::*;

  localparam int unsigned VOICES     = VOICE_COUNT_DEF;
  localparam int unsigned AGE_W      = AGE_BITS_DEF;
  localparam int          RANDOM_REQ = 1125;
  localparam int          CYCLE_CAP  = 60000;
  localparam int          DRAIN_CAP  = 200;

  // opcodes outside the decoded set
  localparam logic [OP_W-1:0] OP_RSVD_LO = OP_W'(OP_KILL_ALL + 1);
  localparam logic [OP_W-1:0] OP_RSVD_HI = '1;

  // scoreboard: voice table copy and queue of pending responses
  class voice_scoreboard;
    bit               used [VOICES];
    bit               gate [VOICES];
    bit [NOTE_W-1:0]  held [VOICES];
    bit [AGE_W-1:0]   age  [VOICES];
    bit [AGE_W-1:0]   stamp;
    rsp_t             pending[$];
    int               errors;

    function new();
      for (int i = 0; i < VOICES; i++) begin
        used[i] = 1'b0;
        gate[i] = 1'b0;
        held[i] = '0;
        age[i]  = '0;
      end
      stamp  = '0;
      errors = 0;
    endfunction

    // apply one request to the voice table and build its response
    function rsp_t allocate(req_t r);
      rsp_t           res;
      int             pick;
      kind_e          kind;
      logic [MASK_W-1:0] mask;
      res  = '0;
      mask = '0;
      case (r.operation)
        OP_NOTE_ON: begin
          // lowest free voice first
          pick = -1;
          kind = KIND_FREE;
          for (int i = 0; i < VOICES; i++)
            if (!used[i] && pick < 0) pick = i;
          // then the oldest released voice
          if (pick < 0) begin
            kind = KIND_RELEASED;
            for (int i = 0; i < VOICES; i++)
              if (!gate[i] && (pick < 0 || age[i] < age[pick])) pick = i;
          end
          // then steal the oldest voice outright
          if (pick < 0) begin
            kind = KIND_STOLEN;
            pick = 0;
            for (int i = 1; i < VOICES; i++)
              if (age[i] < age[pick]) pick = i;
          end
          stamp      = stamp + 1'b1;
          used[pick] = 1'b1;
          gate[pick] = 1'b1;
          held[pick] = r.note_number;
          age[pick]  = stamp;
          res.chosen_voice   = CHOSEN_W'(pick);
          res.steal_kind     = kind;
          res.start_note     = r.note_number;
          res.start_velocity = r.note_velocity;
          res.started        = 1'b1;
        end
        OP_NOTE_OFF: begin
          for (int i = 0; i < VOICES; i++)
            if (used[i] && gate[i] && held[i] == r.note_number) begin
              gate[i] = 1'b0;
              if (i < MASK_W) mask[i] = 1'b1;
            end
        end
        OP_ALL_OFF, OP_KILL_ALL: begin
          for (int i = 0; i < VOICES; i++) begin
            if (gate[i] && i < MASK_W) mask[i] = 1'b1;
            gate[i] = 1'b0;
            if (r.operation == OP_KILL_ALL) used[i] = 1'b0;
          end
        end
        OP_VOICE_DONE: begin
          if (r.finished_voice < VOICES) begin
            if (gate[r.finished_voice] && r.finished_voice < MASK_W)
              mask[r.finished_voice] = 1'b1;
            gate[r.finished_voice] = 1'b0;
            used[r.finished_voice] = 1'b0;
          end
        end
        default: ;
      endcase
      res.released_mask = mask;
      return res;
    endfunction

    function void note_request(req_t r);
      pending.push_back(allocate(r));
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got.chosen_voice !== want.chosen_voice)
        report("chosen_voice", want.chosen_voice, got.chosen_voice);
      if (got.steal_kind !== want.steal_kind)
        report("steal_kind", want.steal_kind, got.steal_kind);
      if (got.start_note !== want.start_note)
        report("start_note", want.start_note, got.start_note);
      if (got.start_velocity !== want.start_velocity)
        report("start_velocity", want.start_velocity, got.start_velocity);
      if (got.released_mask !== want.released_mask)
        report("released_mask", want.released_mask, got.released_mask);
      if (got.started !== want.started)
        report("started", want.started, got.started);
    endfunction
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  req_t   req_i = '0;
  logic   rsp_valid_o;
  rsp_t   rsp_o;
  int     cycles = 0;
  bit     quiet = 1'b0;

  voice_scoreboard sb = new();

  voice_allocator_oldest_steal_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("** voice_allocator_oldest_steal_top: FAILED **");
      $finish;
    end
  end

  // response monitor, values sampled before the edge updates them
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) sb.check_result(rsp_o);
  end

  function automatic req_t make_req(logic [OP_W-1:0] op, int unsigned note,
                                    int unsigned vel, int unsigned fin);
    req_t r;
    r.operation      = op;
    r.note_number    = NOTE_W'(note);
    r.note_velocity  = VEL_W'(vel);
    r.finished_voice = FIN_W'(fin);
    return r;
  endfunction

  // random gap between requests, none while quiet
  task automatic gap();
    int n;
    n = 0;
    if (!quiet) begin
      while ($urandom_range(0, 99) < 35) n++;
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // hold the request until an edge sees busy low
  task automatic send_req(req_t r);
    gap();
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
  endtask

  initial begin
    req_t        r;
    req_t        plan[$];
    int unsigned pick;
    int          waited;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fill, steal, release, reuse, finish, clear
    plan.push_back(make_req(OP_NOTE_ON, 0, 0, 0));
    plan.push_back(make_req(OP_NOTE_ON, 127, 127, 0));
    plan.push_back(make_req(OP_NOTE_ON, 64, 10, 0));
    plan.push_back(make_req(OP_NOTE_ON, 64, 20, 0));
    for (int i = 1; i <= 4; i++) plan.push_back(make_req(OP_NOTE_ON, i, 30 + i, 0));
    plan.push_back(make_req(OP_NOTE_ON, 100, 50, 0));      // all gated: steal
    plan.push_back(make_req(OP_NOTE_OFF, 64, 0, 0));       // two voices at once
    plan.push_back(make_req(OP_NOTE_OFF, 99, 0, 0));       // note not held
    plan.push_back(make_req(OP_NOTE_ON, 5, 60, 0));        // reuse released voice
    plan.push_back(make_req(OP_VOICE_DONE, 0, 0, 7));      // gated voice ends
    plan.push_back(make_req(OP_NOTE_ON, 6, 70, 0));        // free voice again
    plan.push_back(make_req(OP_NOTE_OFF, 127, 0, 0));
    plan.push_back(make_req(OP_ALL_OFF, 0, 0, 0));
    plan.push_back(make_req(OP_NOTE_ON, 7, 80, 0));
    plan.push_back(make_req(OP_VOICE_DONE, 0, 0, 3));      // gate already off
    plan.push_back(make_req(OP_KILL_ALL, 0, 0, 0));
    plan.push_back(make_req(OP_RSVD_LO, 127, 127, 7));
    plan.push_back(make_req(OP_W'(OP_RSVD_LO + 1), 0, 0, 0));
    plan.push_back(make_req(OP_RSVD_HI, 127, 127, 7));
    plan.push_back(make_req(OP_VOICE_DONE, 0, 0, 0));      // voice not in use
    plan.push_back(make_req(OP_NOTE_ON, 127, 127, 7));
    plan.push_back(make_req(OP_NOTE_OFF, 0, 0, 0));
    foreach (plan[i]) send_req(plan[i]);

    // random: mostly note on / note off on a narrow note band
    for (int k = 0; k < RANDOM_REQ; k++) begin
      quiet = (k >= 400 && k < 650);
      r.note_number = ($urandom_range(0, 99) < 70) ? NOTE_W'($urandom_range(60, 71))
                                                     : NOTE_W'($urandom_range(0, 127));
      r.note_velocity  = VEL_W'($urandom_range(0, 127));
      r.finished_voice = FIN_W'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 45)      r.operation = OP_NOTE_ON;
      else if (pick < 70) r.operation = OP_NOTE_OFF;
      else if (pick < 84) r.operation = OP_VOICE_DONE;
      else if (pick < 90) r.operation = OP_ALL_OFF;
      else if (pick < 94) r.operation = OP_KILL_ALL;
      else                r.operation = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      send_req(r);
    end

    // drain outstanding responses, then let the bench idle before the verdict
    start <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** voice_allocator_oldest_steal_top: PASSED **");
    end else begin
      if (sb.pending.size() != 0)
        $display("%0t: %0d responses never arrived", $time, sb.pending.size());
      $display("** voice_allocator_oldest_steal_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
